@@ design/tsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, reciprocal multipliers and pipeline control type for the
// timestamp tick adder. No dependencies.

package tsa_pkg;

	// Calendar and clock units
	localparam int TICKS_PER_SEC = 10000;
	localparam int SECS_PER_MIN  = 60;
	localparam int MINS_PER_HOUR = 60;
	localparam int SECS_PER_HOUR = 3600;
	localparam int HOURS_PER_DAY = 24;
	localparam int DAYS_COMMON   = 365;
	localparam int DAYS_LEAP     = 366;

	// Stream word widths
	localparam int IN_W  = 96;
	localparam int OUT_W = 56;

	// Pipeline depth
	localparam int STAGES = 11;

	// Divide by 10000 as a shift by 4 and a divide by 625
	localparam int TICK_SHIFT = 4;
	localparam int TICK_ODD   = TICKS_PER_SEC / 16;
	// Divide by 3600 as a shift by 4 and a divide by 225
	localparam int HOUR_SEC_SHIFT = 4;
	localparam int HOUR_SEC_ODD   = SECS_PER_HOUR / 16;
	// Divide by 24 as a shift by 3 and a divide by 3
	localparam int DAY_SHIFT = 3;
	localparam int DAY_ODD   = HOURS_PER_DAY / 8;
	// Century tests of the leap rule use a divide by 25
	localparam int CENT_ODD = 25;

	// Reciprocals, rounded up, exact over the operand ranges used
	localparam int R625_SH = 38;
	localparam logic [28:0] RECIP_625 =
		29'(((64'd1 << R625_SH) + 64'(TICK_ODD) - 64'd1) / 64'(TICK_ODD));
	localparam int R225_SH = 30;
	localparam logic [22:0] RECIP_225 =
		23'(((64'd1 << R225_SH) + 64'(HOUR_SEC_ODD) - 64'd1) / 64'(HOUR_SEC_ODD));
	localparam int R60_SH = 18;
	localparam logic [12:0] RECIP_60 =
		13'(((64'd1 << R60_SH) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));
	localparam int R3_SH = 13;
	localparam logic [11:0] RECIP_3 =
		12'(((64'd1 << R3_SH) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
	localparam int R25_SH = 17;
	localparam logic [12:0] RECIP_25 =
		13'(((64'd1 << R25_SH) + 64'(CENT_ODD) - 64'd1) / 64'(CENT_ODD));

	// Per-stage load enables and valid flags
	typedef struct packed {
		logic [STAGES-1:0] load;
		logic [STAGES-1:0] valid;
	} pipe_ctrl_t;

endpackage

`default_nettype wire

@@ design/tsa_pipe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Valid and load control for the timestamp adder pipeline.
// Depends on tsa_pkg for the stage count and the control struct.

module tsa_pipe_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               out_ready,
	output logic                    in_ready,
	output tsa_pkg::pipe_ctrl_t     ctrl
);

	logic [tsa_pkg::STAGES-1:0] valid_q;
	logic [tsa_pkg::STAGES-1:0] load;

	// A stage loads when it is empty or its word moves on
	always_comb begin
		load[tsa_pkg::STAGES-1] = !valid_q[tsa_pkg::STAGES-1] || out_ready;
		for (int i = tsa_pkg::STAGES - 2; i >= 0; i--) begin
			load[i] = !valid_q[i] || load[i+1];
		end
	end

	// Advance valid flags with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int i = 1; i < tsa_pkg::STAGES; i++) begin
				if (load[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign in_ready = load[0];
	assign ctrl     = {load, valid_q};

endmodule

`default_nettype wire

@@ design/timestamp_add_ticks.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle; stalls on the output back up stage by stage
// and empty stages are filled while the output waits.
// Depth comes from the reciprocal divide of the increment by 10000 and the carry chain.
// Reset clears the valid flags only; no words are held after reset.
// Depends on tsa_pkg and tsa_pipe_ctrl.

module timestamp_add_ticks (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// s_tdata, lowest bit up: start_year[14], start_day[9], start_hour[5],
	// start_minute[6], start_second[6], start_ticks[14], increment_ticks[39], zero pad[3]
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [tsa_pkg::IN_W-1:0] s_tdata,
	// m_tdata, lowest bit up: sum_year[14], sum_day[9], sum_hour[5],
	// sum_minute[6], sum_second[6], sum_ticks[14], zero pad[2]
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [tsa_pkg::OUT_W-1:0]     m_tdata
);

	typedef struct packed {
		logic [13:0] year;
		logic [8:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [13:0] ticks;
	} stamp_t;

	tsa_pkg::pipe_ctrl_t ctrl;

	tsa_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.in_ready  (s_tready),
		.ctrl      (ctrl)
	);

	// Unpack the input word
	stamp_t      in_stamp;
	logic [38:0] in_incr;

	always_comb begin
		in_stamp.year   = s_tdata[13:0];
		in_stamp.day    = s_tdata[22:14];
		in_stamp.hour   = s_tdata[27:23];
		in_stamp.minute = s_tdata[33:28];
		in_stamp.second = s_tdata[39:34];
		in_stamp.ticks  = s_tdata[53:40];
	end
	assign in_incr = s_tdata[92:54];

	// Stage 1: first quotient digit of (increment >> 4) / 625
	stamp_t      stamp_s1;
	logic [45:0] hprod_s1;
	logic [16:0] hi_s1;
	logic [17:0] lo_s1;
	logic [3:0]  nib_s1;

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			stamp_s1 <= in_stamp;
			hprod_s1 <= 46'(in_incr[38:22]) * 46'(tsa_pkg::RECIP_625);
			hi_s1    <= in_incr[38:22];
			lo_s1    <= in_incr[21:4];
			nib_s1   <= in_incr[3:0];
		end
	end

	// Stage 2: remainder of the first digit, century quotients of the year
	logic [7:0]  q1;
	logic [16:0] rem1_w;
	logic [24:0] y4_prod;
	logic [24:0] y16_prod;

	assign q1       = hprod_s1[45:38];
	assign rem1_w   = hi_s1 - 17'(q1) * 17'(tsa_pkg::TICK_ODD);
	assign y4_prod  = 25'(stamp_s1.year[13:2]) * 25'(tsa_pkg::RECIP_25);
	assign y16_prod = 25'(stamp_s1.year[13:4]) * 25'(tsa_pkg::RECIP_25);

	stamp_t      stamp_s2;
	logic [7:0]  q1_s2;
	logic [27:0] r2_s2;
	logic [3:0]  nib_s2;
	logic [7:0]  c100_s2;
	logic [7:0]  c400_s2;

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			stamp_s2 <= stamp_s1;
			q1_s2    <= q1;
			r2_s2    <= {rem1_w[9:0], lo_s1};
			nib_s2   <= nib_s1;
			c100_s2  <= y4_prod[24:17];
			c400_s2  <= y16_prod[24:17];
		end
	end

	// Stage 3: second digit product, leap year decision
	logic [11:0] y4_rem;
	logic [11:0] y16_rem;
	logic        leap;

	assign y4_rem  = stamp_s2.year[13:2] - 12'(c100_s2) * 12'(tsa_pkg::CENT_ODD);
	assign y16_rem = 12'(stamp_s2.year[13:4]) - 12'(c400_s2) * 12'(tsa_pkg::CENT_ODD);
	assign leap    = ((stamp_s2.year[1:0] == 2'd0) && (y4_rem != 12'd0))
		|| ((stamp_s2.year[3:0] == 4'd0) && (y16_rem == 12'd0));

	stamp_t      stamp_s3;
	logic [7:0]  q1_s3;
	logic [27:0] r2_s3;
	logic [56:0] lprod_s3;
	logic [3:0]  nib_s3;
	logic        leap_s3;

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			stamp_s3 <= stamp_s2;
			q1_s3    <= q1_s2;
			r2_s3    <= r2_s2;
			lprod_s3 <= 57'(r2_s2) * 57'(tsa_pkg::RECIP_625);
			nib_s3   <= nib_s2;
			leap_s3  <= leap;
		end
	end

	// Stage 4: whole seconds and leftover ticks of the increment
	logic [17:0] q2;
	logic [27:0] rem2_w;

	assign q2     = lprod_s3[55:38];
	assign rem2_w = r2_s3 - 28'(q2) * 28'(tsa_pkg::TICK_ODD);

	stamp_t      stamp_s4;
	logic        leap_s4;
	logic [25:0] whole_s4;
	logic [13:0] fine_s4;

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			stamp_s4 <= stamp_s3;
			leap_s4  <= leap_s3;
			whole_s4 <= {q1_s3, q2};
			fine_s4  <= {rem2_w[9:0], nib_s3};
		end
	end

	// Stage 5: hour product of the increment, tick sum and carry
	logic [14:0] tsum;
	logic [1:0]  tcar;
	logic [14:0] tnorm;

	assign tsum = 15'(stamp_s4.ticks) + 15'(fine_s4);

	always_comb begin
		if (tsum >= 15'(2 * tsa_pkg::TICKS_PER_SEC)) begin
			tcar  = 2'd2;
			tnorm = tsum - 15'(2 * tsa_pkg::TICKS_PER_SEC);
		end else if (tsum >= 15'(tsa_pkg::TICKS_PER_SEC)) begin
			tcar  = 2'd1;
			tnorm = tsum - 15'(tsa_pkg::TICKS_PER_SEC);
		end else begin
			tcar  = 2'd0;
			tnorm = tsum;
		end
	end

	stamp_t      stamp_s5;
	logic        leap_s5;
	logic [25:0] whole_s5;
	logic [44:0] hrprod_s5;
	logic [1:0]  tcar_s5;

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			stamp_s5  <= {stamp_s4.year, stamp_s4.day, stamp_s4.hour, stamp_s4.minute,
				stamp_s4.second, tnorm[13:0]};
			leap_s5   <= leap_s4;
			whole_s5  <= whole_s4;
			hrprod_s5 <= 45'(whole_s4[25:4]) * 45'(tsa_pkg::RECIP_225);
			tcar_s5   <= tcar;
		end
	end

	// Stage 6: hours of the increment and seconds left within the hour
	logic [13:0] ihour;
	logic [25:0] secw;

	assign ihour = hrprod_s5[43:30];
	assign secw  = whole_s5 - 26'(ihour) * 26'(tsa_pkg::SECS_PER_HOUR);

	stamp_t      stamp_s6;
	logic        leap_s6;
	logic [1:0]  tcar_s6;
	logic [13:0] ihour_s6;
	logic [11:0] secw_s6;

	always_ff @(posedge clk) begin
		if (ctrl.load[5]) begin
			stamp_s6 <= stamp_s5;
			leap_s6  <= leap_s5;
			tcar_s6  <= tcar_s5;
			ihour_s6 <= ihour;
			secw_s6  <= secw[11:0];
		end
	end

	// Stage 7: minute product of the seconds left
	stamp_t      stamp_s7;
	logic        leap_s7;
	logic [1:0]  tcar_s7;
	logic [13:0] ihour_s7;
	logic [11:0] secw_s7;
	logic [24:0] mprod_s7;

	always_ff @(posedge clk) begin
		if (ctrl.load[6]) begin
			stamp_s7 <= stamp_s6;
			leap_s7  <= leap_s6;
			tcar_s7  <= tcar_s6;
			ihour_s7 <= ihour_s6;
			secw_s7  <= secw_s6;
			mprod_s7 <= 25'(secw_s6) * 25'(tsa_pkg::RECIP_60);
		end
	end

	// Stage 8: minutes and seconds of the increment
	logic [5:0]  imin;
	logic [11:0] isec_w;

	assign imin   = mprod_s7[23:18];
	assign isec_w = secw_s7 - 12'(imin) * 12'(tsa_pkg::SECS_PER_MIN);

	stamp_t      stamp_s8;
	logic        leap_s8;
	logic [1:0]  tcar_s8;
	logic [13:0] ihour_s8;
	logic [5:0]  imin_s8;
	logic [5:0]  isec_s8;

	always_ff @(posedge clk) begin
		if (ctrl.load[7]) begin
			stamp_s8 <= stamp_s7;
			leap_s8  <= leap_s7;
			tcar_s8  <= tcar_s7;
			ihour_s8 <= ihour_s7;
			imin_s8  <= imin;
			isec_s8  <= isec_w[5:0];
		end
	end

	// Stage 9: add and fold seconds, then minutes
	logic [6:0] ssum;
	logic [1:0] scar;
	logic [6:0] snorm;
	logic [6:0] msum;
	logic [1:0] mcar;
	logic [6:0] mnorm;

	always_comb begin
		ssum = 7'(stamp_s8.second) + 7'(isec_s8) + 7'(tcar_s8);
		if (ssum >= 7'(2 * tsa_pkg::SECS_PER_MIN)) begin
			scar  = 2'd2;
			snorm = ssum - 7'(2 * tsa_pkg::SECS_PER_MIN);
		end else if (ssum >= 7'(tsa_pkg::SECS_PER_MIN)) begin
			scar  = 2'd1;
			snorm = ssum - 7'(tsa_pkg::SECS_PER_MIN);
		end else begin
			scar  = 2'd0;
			snorm = ssum;
		end
		msum = 7'(stamp_s8.minute) + 7'(imin_s8) + 7'(scar);
		if (msum >= 7'(2 * tsa_pkg::MINS_PER_HOUR)) begin
			mcar  = 2'd2;
			mnorm = msum - 7'(2 * tsa_pkg::MINS_PER_HOUR);
		end else if (msum >= 7'(tsa_pkg::MINS_PER_HOUR)) begin
			mcar  = 2'd1;
			mnorm = msum - 7'(tsa_pkg::MINS_PER_HOUR);
		end else begin
			mcar  = 2'd0;
			mnorm = msum;
		end
	end

	stamp_t      stamp_s9;
	logic        leap_s9;
	logic [13:0] ihour_s9;
	logic [1:0]  mcar_s9;

	always_ff @(posedge clk) begin
		if (ctrl.load[8]) begin
			stamp_s9 <= {stamp_s8.year, stamp_s8.day, stamp_s8.hour, mnorm[5:0],
				snorm[5:0], stamp_s8.ticks};
			leap_s9  <= leap_s8;
			ihour_s9 <= ihour_s8;
			mcar_s9  <= mcar;
		end
	end

	// Stage 10: hour sum and its day product
	logic [14:0] hsum;

	assign hsum = 15'(stamp_s9.hour) + 15'(ihour_s9) + 15'(mcar_s9);

	stamp_t      stamp_s10;
	logic        leap_s10;
	logic [14:0] hsum_s10;
	logic [23:0] dprod_s10;

	always_ff @(posedge clk) begin
		if (ctrl.load[9]) begin
			stamp_s10 <= stamp_s9;
			leap_s10  <= leap_s9;
			hsum_s10  <= hsum;
			dprod_s10 <= 24'(hsum[14:tsa_pkg::DAY_SHIFT]) * 24'(tsa_pkg::RECIP_3);
		end
	end

	// Stage 11: fold hours into days, advance the year once if needed
	logic [9:0]  dcar;
	logic [14:0] hrem;
	logic [10:0] dsum;
	logic [10:0] ylen;
	stamp_t      res;

	assign dcar = dprod_s10[22:13];
	assign hrem = hsum_s10 - 15'(dcar) * 15'(tsa_pkg::HOURS_PER_DAY);
	assign dsum = 11'(stamp_s10.day) + 11'(dcar);
	assign ylen = leap_s10 ? 11'(tsa_pkg::DAYS_LEAP) : 11'(tsa_pkg::DAYS_COMMON);

	always_comb begin
		res      = stamp_s10;
		res.hour = hrem[4:0];
		if (dsum > ylen) begin
			res.year = stamp_s10.year + 14'd1;
			res.day  = 9'(dsum - ylen);
		end else begin
			res.day  = dsum[8:0];
		end
	end

	stamp_t stamp_s11;

	always_ff @(posedge clk) begin
		if (ctrl.load[10]) begin
			stamp_s11 <= res;
		end
	end

	// Pack the output word
	assign m_tvalid = ctrl.valid[tsa_pkg::STAGES-1];
	assign m_tdata  = {2'b00, stamp_s11.ticks, stamp_s11.second, stamp_s11.minute,
		stamp_s11.hour, stamp_s11.day, stamp_s11.year};

endmodule

`default_nettype wire

@@ design/tsa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for timestamp_add_ticks, attached by bind.
// Depends on tsa_pkg for the field limits.

module tsa_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic [tsa_pkg::IN_W-1:0]  s_tdata,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [tsa_pkg::OUT_W-1:0] m_tdata
);

	// Hold an offered input word until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input word changed while waiting");

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Keep the time of day normalized in every result
	a_out_norm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[27:23] < 5'(tsa_pkg::HOURS_PER_DAY))
			&& (m_tdata[33:28] < 6'(tsa_pkg::MINS_PER_HOUR))
			&& (m_tdata[39:34] < 6'(tsa_pkg::SECS_PER_MIN))
			&& (m_tdata[53:40] < 14'(tsa_pkg::TICKS_PER_SEC)))
		else $error("result time of day out of range");

	// A free output means the whole pipeline moves, so input is open
	a_flow: assert property (@(posedge clk)
		m_tready |-> s_tready)
		else $error("input blocked while output is ready");

	// Come out of reset with no result pending
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result word shown right after reset");

endmodule

bind timestamp_add_ticks tsa_checker u_tsa_checker (.*);

`default_nettype wire

@@ verif/timestamp_sum_checker.sv @@
`timescale 1ns / 1ps
// Watches both stream channels of timestamp_add_ticks, predicts each result word
// from the accepted input word and compares them field by field in order.
// Depends on tsa_pkg for the word widths and the calendar constants.

module timestamp_sum_checker (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	input  wire logic                     s_tready,
	input  wire logic [tsa_pkg::IN_W-1:0] s_tdata,
	input  wire logic                     m_tvalid,
	input  wire logic                     m_tready,
	input  wire logic [tsa_pkg::OUT_W-1:0] m_tdata,
	output int                            fail_count,
	output int                            pending_results
);
	import tsa_pkg::*;

	// Input word, highest field first
	typedef struct packed {
		logic [2:0]  pad;
		logic [38:0] increment_ticks;
		logic [13:0] start_ticks;
		logic [5:0]  start_second;
		logic [5:0]  start_minute;
		logic [4:0]  start_hour;
		logic [8:0]  start_day;
		logic [13:0] start_year;
	} stamp_word_t;

	// Result word, highest field first
	typedef struct packed {
		logic [1:0]  pad;
		logic [13:0] sum_ticks;
		logic [5:0]  sum_second;
		logic [5:0]  sum_minute;
		logic [4:0]  sum_hour;
		logic [8:0]  sum_day;
		logic [13:0] sum_year;
	} sum_word_t;

	sum_word_t sums_due[$];

	// Split the increment, add each part, then ripple the carries up to the year
	function automatic sum_word_t advance_stamp(stamp_word_t a);
		longint unsigned whole, rem, yr, dy, hr, mi, se, tk, days_in_year;
		sum_word_t r;
		whole = a.increment_ticks / TICKS_PER_SEC;
		rem = whole % SECS_PER_HOUR;
		yr = a.start_year;
		dy = a.start_day;
		hr = a.start_hour;
		mi = a.start_minute;
		se = a.start_second;
		tk = a.start_ticks;
		hr = hr + whole / SECS_PER_HOUR;
		mi = mi + rem / SECS_PER_MIN;
		se = se + rem % SECS_PER_MIN;
		tk = tk + a.increment_ticks % TICKS_PER_SEC;

		se = se + tk / TICKS_PER_SEC;
		tk = tk % TICKS_PER_SEC;
		mi = mi + se / SECS_PER_MIN;
		se = se % SECS_PER_MIN;
		hr = hr + mi / MINS_PER_HOUR;
		mi = mi % MINS_PER_HOUR;
		dy = dy + hr / HOURS_PER_DAY;
		hr = hr % HOURS_PER_DAY;

		// One year step at most, judged on the starting year only
		if (((yr % 100 != 0) && (yr % 4 == 0)) || (yr % 400 == 0))
			days_in_year = DAYS_LEAP;
		else
			days_in_year = DAYS_COMMON;
		if (dy > days_in_year) begin
			yr = yr + 1;
			dy = dy - days_in_year;
		end

		r = '0;
		r.sum_year = yr[13:0];
		r.sum_day = dy[8:0];
		r.sum_hour = hr[4:0];
		r.sum_minute = mi[5:0];
		r.sum_second = se[5:0];
		r.sum_ticks = tk[13:0];
		return r;
	endfunction

	function automatic int field_differs(string name, longint unsigned want,
			longint unsigned got);
		if (want == got)
			return 0;
		$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
		return 1;
	endfunction

	// Queue a prediction per accepted input word, retire one per result word
	always @(posedge clk or negedge arst_n) begin
		sum_word_t got, want;
		int errs;
		if (!arst_n) begin
			sums_due.delete();
			fail_count <= 0;
			pending_results <= 0;
		end else begin
			errs = 0;
			if (s_tvalid && s_tready)
				sums_due.push_back(advance_stamp(stamp_word_t'(s_tdata)));
			if (m_tvalid && m_tready) begin
				got = sum_word_t'(m_tdata);
				if (sums_due.size() == 0) begin
					$display("%0t ns: result word %h with none expected", $time, m_tdata);
					errs++;
				end else begin
					want = sums_due.pop_front();
					errs += field_differs("sum_year", want.sum_year, got.sum_year);
					errs += field_differs("sum_day", want.sum_day, got.sum_day);
					errs += field_differs("sum_hour", want.sum_hour, got.sum_hour);
					errs += field_differs("sum_minute", want.sum_minute, got.sum_minute);
					errs += field_differs("sum_second", want.sum_second, got.sum_second);
					errs += field_differs("sum_ticks", want.sum_ticks, got.sum_ticks);
				end
			end
			fail_count <= fail_count + errs;
			pending_results <= sums_due.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Top of the timestamp_add_ticks regression: clock, reset, input and output
// stream drivers, and the verdict. Depends on tsa_pkg and timestamp_sum_checker.

module testbench;
	import tsa_pkg::*;

	localparam int N_RANDOM = 1750;
	localparam int CALM_TAIL = 200;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 120;
	localparam logic [38:0] YEAR_TICKS_MAX = 39'd315359999999;
	localparam logic [38:0] DAY_TICKS = 39'd864000000;
	localparam logic [38:0] HOUR_TICKS = 39'd36000000;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [IN_W-1:0] s_tdata;
	logic [OUT_W-1:0] m_tdata;
	int fail_count, pending_results;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	timestamp_add_ticks i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	timestamp_sum_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	function automatic logic [IN_W-1:0] pack_stamp(logic [13:0] yr, logic [8:0] dy,
			logic [4:0] hr, logic [5:0] mi, logic [5:0] se, logic [13:0] tk,
			logic [38:0] inc);
		logic [IN_W-1:0] w;
		w = {3'b000, inc, tk, se, mi, hr, dy, yr};
		return w;
	endfunction

	function automatic logic [38:0] rand_ticks(logic [38:0] ceiling);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return 39'(r % (64'(ceiling) + 64'd1));
	endfunction

	// Mostly legal timestamps, many close to the year end, plus full-width noise
	function automatic logic [IN_W-1:0] rand_stamp();
		logic [13:0] yr, tk;
		logic [8:0] dy;
		logic [4:0] hr;
		logic [5:0] mi, se;
		logic [38:0] inc;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		yr = 14'($urandom_range(0, 9999));
		if ($urandom_range(0, 3) == 0)
			yr = 14'(100 * $urandom_range(0, 99));
		dy = 9'($urandom_range(1, 366));
		hr = 5'($urandom_range(0, 23));
		mi = 6'($urandom_range(0, 59));
		se = 6'($urandom_range(0, 59));
		tk = 14'($urandom_range(0, 9999));
		inc = rand_ticks(YEAR_TICKS_MAX);
		if (pick < 35) begin
			dy = 9'($urandom_range(355, 366));
			hr = 5'($urandom_range(20, 23));
			inc = rand_ticks(39'd2000000000);
		end else if (pick < 55) begin
			inc = rand_ticks(DAY_TICKS);
		end else if (pick < 65) begin
			inc = 39'($urandom_range(0, 99999));
		end else if (pick < 88) begin
			yr = 14'($urandom);
			dy = 9'($urandom);
			hr = 5'($urandom);
			mi = 6'($urandom);
			se = 6'($urandom);
			tk = 14'($urandom);
			inc = 39'({$urandom, $urandom});
		end
		return pack_stamp(yr, dy, hr, mi, se, tk, inc);
	endfunction

	// Idle a random burst now and then, then hold the word until accepted
	task automatic offer_stamp(logic [IN_W-1:0] w);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
	endtask

	// Output side: random stalls, one long hold-off, no stalls at the tail
	initial begin : sink
		int n;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int k;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words: range extremes and the year boundaries
		offer_stamp(pack_stamp(14'd0, 9'd1, 5'd0, 6'd0, 6'd0, 14'd0, 39'd0));
		offer_stamp(pack_stamp(14'd9999, 9'd366, 5'd23, 6'd59, 6'd59, 14'd9999,
			YEAR_TICKS_MAX));
		offer_stamp(pack_stamp(14'd2023, 9'd365, 5'd23, 6'd59, 6'd59, 14'd9999, 39'd1));
		offer_stamp(pack_stamp(14'd2024, 9'd366, 5'd23, 6'd59, 6'd59, 14'd9999, 39'd1));
		offer_stamp(pack_stamp(14'd2024, 9'd365, 5'd23, 6'd59, 6'd59, 14'd9999, 39'd1));
		offer_stamp(pack_stamp(14'd2100, 9'd365, 5'd23, 6'd59, 6'd59, 14'd9999, 39'd1));
		offer_stamp(pack_stamp(14'd2000, 9'd366, 5'd23, 6'd59, 6'd59, 14'd9999, 39'd1));
		offer_stamp(pack_stamp(14'd16383, 9'd365, 5'd23, 6'd59, 6'd59, 14'd9999, 39'd1));
		offer_stamp(pack_stamp(14'd1, 9'd1, 5'd0, 6'd0, 6'd0, 14'd0, '1));
		offer_stamp(pack_stamp('1, '1, '1, '1, '1, '1, '1));
		offer_stamp(pack_stamp(14'd1999, 9'd100, 5'd12, 6'd30, 6'd30, 14'd1, 39'd9999));
		offer_stamp(pack_stamp(14'd1900, 9'd365, 5'd0, 6'd0, 6'd0, 14'd0, DAY_TICKS));
		offer_stamp(pack_stamp(14'd1600, 9'd366, 5'd0, 6'd0, 6'd0, 14'd0, HOUR_TICKS));
		offer_stamp(pack_stamp(14'd2021, 9'd200, 5'd23, 6'd59, 6'd59, 14'd0, 39'd10000));
		offer_stamp(pack_stamp(14'd2022, 9'd1, 5'd0, 6'd0, 6'd0, 14'd0, 39'd35999999));
		offer_stamp(pack_stamp(14'd8, 9'd2, 5'd1, 6'd1, 6'd1, 14'd1, YEAR_TICKS_MAX));

		for (k = 0; k < N_RANDOM; k++) begin
			if (k == HOLD_AT)
				hold_req = 1'b1;
			if (k == N_RANDOM - CALM_TAIL)
				calm = 1'b1;
			offer_stamp(rand_stamp());
		end
		s_tvalid <= 1'b0;

		// Drain, then give the pipeline time to show any stray word
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (STAGES + 4) @(posedge clk);
		if (fail_count == 0)
			$display("timestamp_add_ticks regression: pass");
		else
			$display("timestamp_add_ticks regression: fail");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("timestamp_add_ticks regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
design/tsa_pkg.sv
design/tsa_pipe_ctrl.sv
design/timestamp_add_ticks.sv
design/tsa_checker.sv
verif/timestamp_sum_checker.sv
verif/testbench.sv
